// File: design/tatc_pkg.sv
// ----------------------------------------------------------------------------
// tatc_pkg
// Shared constants, the resistance table and the stage types of the NTC
// thermistor sample-to-temperature pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tatc_pkg;

   // table size and resistance format
   localparam int TABLE_ENTRIES  = 54;
   localparam int FRAC_BITS      = 12;
   localparam int STORED_ENTRIES = 54;
   localparam int NUM_ENTRIES    = (TABLE_ENTRIES < STORED_ENTRIES) ?
                                   TABLE_ENTRIES : STORED_ENTRIES;
   localparam int NUM_INTERVALS  = NUM_ENTRIES - 1;
   localparam int IDX_W          = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;

   // converter and divider
   localparam int              ADC_W        = 12;
   localparam logic [ADC_W-1:0] ADC_FULL    = {ADC_W{1'b1}};
   localparam int              DIVIDER_KOHM = 10;
   // 10 * 4094 fits in 16 bits, so the dividend carries 4 extra integer bits
   localparam int              NUM_W        = ADC_W + 4 + FRAC_BITS;
   localparam int              DIV_STEPS    = 4;
   localparam int              DIV_STAGES   = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

   // table entries are below 64 kOhm
   localparam int TAB_W      = 6 + FRAC_BITS;
   localparam int KOHM_E4_W  = 19;
   localparam int NTC_SCALE  = 10000;

   // interpolation
   localparam int TENTHS      = 10;
   localparam int BASE_OFFSET = 10;
   localparam int NUMER_W     = TAB_W + 4;
   localparam int QUO_W       = 4;
   localparam int QUO_IW      = 2;
   localparam int BASE_W      = 11;
   localparam int TEMP_W      = 10;

   // stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // resistance per degree from -10 C, in units of 1e-4 kOhm
   localparam logic [KOHM_E4_W-1:0] NTC_KOHM_E4 [STORED_ENTRIES] = '{
      19'd441201, 19'd421180, 19'd402121, 19'd383988, 19'd366746,
      19'd350362, 19'd334802, 19'd320035, 19'd306028, 19'd292750,
      19'd280170, 19'd268255, 19'd256972, 19'd246290, 19'd236176,
      19'd226597, 19'd217522, 19'd208916, 19'd200749, 19'd192988,
      19'd185600, 19'd184818, 19'd176316, 19'd169917, 19'd162797,
      19'd155350, 19'd147867, 19'd140551, 19'd133536, 19'd126900,
      19'd120684, 19'd114900, 19'd109539, 19'd104582, 19'd100000,
      19'd95762,  19'd91835,  19'd88186,  19'd84784,  19'd81600,
      19'd75785,  19'd73109,  19'd70564,  19'd68133,  19'd65806,
      19'd63570,  19'd61418,  19'd59343,  19'd57340,  19'd55405,
      19'd53534,  19'd51725,  19'd49976,  19'd48286
   };

   typedef logic [TAB_W-1:0] tab_arr_type [NUM_ENTRIES];

   // convert entries to the resistance format, rounding half up
   function automatic tab_arr_type build_table();
      tab_arr_type t;
      longint      v;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         v    = longint'(NTC_KOHM_E4[i]);
         t[i] = TAB_W'(((v << FRAC_BITS) + NTC_SCALE / 2) / NTC_SCALE);
      end
      return t;
   endfunction

   localparam tab_arr_type NTC_TABLE = build_table();

   // resistance out of the divider
   typedef struct packed {
      logic             bad;
      logic [NUM_W-1:0] r;
   } tatc_res_type;

   // selected interval
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [TAB_W-1:0] hi;
      logic [TAB_W-1:0] lo;
      logic [NUM_W-1:0] r;
   } tatc_sel_type;

   // finished result
   typedef struct packed {
      logic [TEMP_W-1:0] temp_tenths;
      logic              valid_res;
   } tatc_out_type;

endpackage

`default_nettype wire

// File: design/tatc_divider.sv
// ----------------------------------------------------------------------------
// tatc_divider
// Pipelined restoring divider: R = 10*adc*2^FRAC_BITS / (4095 - adc),
// DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tatc_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_vld,
   input  wire logic [tatc_pkg::ADC_W-1:0]  adc_sample,
   output      logic                        out_vld,
   output      tatc_pkg::tatc_res_type      out_res
);
   import tatc_pkg::*;

   typedef struct packed {
      logic             bad;
      logic [ADC_W-1:0] dvs;
      logic [ADC_W-1:0] rem;
      logic [NUM_W-1:0] nq;
   } div_type;

   div_type                div_src;
   div_type                div_in [DIV_STAGES];
   div_type                div_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0]  vld_ff;
   logic [DIV_STAGES-1:0]  vld_in;

   // dividend, divisor and the full-scale flag
   always_comb begin
      div_src.bad = (adc_sample == ADC_FULL);
      div_src.dvs = ADC_FULL - adc_sample;
      div_src.rem = '0;
      div_src.nq  = NUM_W'(NUM_W'(adc_sample) * NUM_W'(DIVIDER_KOHM)) << FRAC_BITS;
   end

   assign vld_in = {vld_ff[DIV_STAGES-2:0], in_vld};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_type src;

      if (s == 0) begin : g_first
         assign src = div_src;
      end else begin : g_next
         assign src = div_ff[s-1];
      end

      // shift in DIV_STEPS dividend bits one by one, subtracting the divisor where it fits
      always_comb begin
         div_type          w;
         logic [ADC_W:0]   t;
         logic             fit;
         w = src;
         for (int k = 0; k < DIV_STEPS; k++) begin
            if (s * DIV_STEPS + k < NUM_W) begin
               t     = {w.rem, w.nq[NUM_W-1]};
               fit   = (t >= {1'b0, w.dvs});
               w.rem = fit ? ADC_W'(t - {1'b0, w.dvs}) : t[ADC_W-1:0];
               w.nq  = {w.nq[NUM_W-2:0], fit};
            end
         end
         div_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign out_vld     = vld_ff[DIV_STAGES-1];
   assign out_res.bad = div_ff[DIV_STAGES-1].bad;
   assign out_res.r   = div_ff[DIV_STAGES-1].nq;

endmodule

`default_nettype wire

// File: design/tatc_search.sv
// ----------------------------------------------------------------------------
// tatc_search
// Compares the resistance with the lower bound of every interval and picks
// the first interval whose lower bound lies at or below it.
// ----------------------------------------------------------------------------
`default_nettype none

module tatc_search (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_vld,
   input  wire tatc_pkg::tatc_res_type  in_res,
   output      logic                    out_vld,
   output      tatc_pkg::tatc_sel_type  out_sel
);
   import tatc_pkg::*;

   logic [NUM_INTERVALS-1:0] ge_in;
   logic [NUM_INTERVALS-1:0] ge_ff;
   tatc_res_type             res_ff;
   tatc_sel_type             sel_in;
   tatc_sel_type             sel_ff;
   logic [1:0]               vld_ff;

   // lower bound of each interval against the resistance
   always_comb begin
      for (int j = 0; j < NUM_INTERVALS; j++) begin
         ge_in[j] = (in_res.r >= NUM_W'(NTC_TABLE[j+1]));
      end
   end

   // first interval with its lower bound reached, and-or select of its bounds
   always_comb begin
      logic [NUM_INTERVALS-1:0] first;
      first[0] = ge_ff[0];
      for (int j = 1; j < NUM_INTERVALS; j++) begin
         first[j] = ge_ff[j] & ~ge_ff[j-1];
      end
      sel_in.hit = (|ge_ff) & ~res_ff.bad;
      sel_in.r   = res_ff.r;
      sel_in.idx = '0;
      sel_in.hi  = '0;
      sel_in.lo  = '0;
      for (int j = 0; j < NUM_INTERVALS; j++) begin
         sel_in.idx = sel_in.idx | (first[j] ? IDX_W'(j) : '0);
         sel_in.hi  = sel_in.hi  | (first[j] ? NTC_TABLE[j] : '0);
         sel_in.lo  = sel_in.lo  | (first[j] ? NTC_TABLE[j+1] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ge_ff  <= ge_in;
         res_ff <= in_res;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_vld};
      end
   end

   assign out_vld = vld_ff[1];
   assign out_sel = sel_ff;

endmodule

`default_nettype wire

// File: design/tatc_interp.sv
// ----------------------------------------------------------------------------
// tatc_interp
// Linear interpolation inside the selected interval: fraction by a short
// restoring divide over two stages, truncation toward zero, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tatc_interp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_vld,
   input  wire tatc_pkg::tatc_sel_type  in_sel,
   output      logic                    out_vld,
   output      tatc_pkg::tatc_out_type  out_res
);
   import tatc_pkg::*;

   typedef struct packed {
      logic               ok;
      logic [BASE_W-1:0]  base;
      logic [TAB_W-1:0]   den;
      logic [NUMER_W-1:0] rem;
      logic [QUO_W-1:0]   quo;
   } frac_type;

   frac_type     frac3_in, frac3_ff;
   frac_type     frac4_in, frac4_ff;
   frac_type     frac5_in, frac5_ff;
   tatc_out_type out_in,   out_ff;
   logic [3:0]   vld_ff;

   // one restoring step for quotient bit b
   function automatic frac_type frac_step(frac_type f, logic [QUO_IW-1:0] b);
      logic [NUMER_W-1:0] sub;
      sub = NUMER_W'(f.den) << b;
      if (f.den != '0 && f.rem >= sub) begin
         f.rem    = f.rem - sub;
         f.quo[b] = 1'b1;
      end
      return f;
   endfunction

   // range check, numerator 10*(hi-r), denominator hi-lo, whole degrees
   always_comb begin
      logic             rng;
      logic [TAB_W-1:0] diff;
      rng  = in_sel.hit && (in_sel.r <= NUM_W'(in_sel.hi));
      diff = in_sel.hi - in_sel.r[TAB_W-1:0];
      frac3_in.ok   = rng;
      frac3_in.base = BASE_W'(BASE_W'(in_sel.idx) * BASE_W'(TENTHS))
                      - BASE_W'(BASE_OFFSET * TENTHS);
      frac3_in.den  = rng ? (in_sel.hi - in_sel.lo) : '0;
      frac3_in.rem  = rng ? NUMER_W'(NUMER_W'(diff) * NUMER_W'(TENTHS)) : '0;
      frac3_in.quo  = '0;
   end

   // upper two quotient bits, then lower two
   assign frac4_in = frac_step(frac_step(frac3_ff, QUO_IW'(QUO_W - 1)), QUO_IW'(QUO_W - 2));
   assign frac5_in = frac_step(frac_step(frac4_ff, QUO_IW'(QUO_W - 3)), QUO_IW'(QUO_W - 4));

   // below zero a leftover remainder moves the sum one step toward zero
   always_comb begin
      logic [BASE_W-1:0] sum;
      logic              bump;
      bump = frac5_ff.base[BASE_W-1] && (frac5_ff.rem != '0);
      sum  = frac5_ff.base + BASE_W'(frac5_ff.quo) + BASE_W'(bump);
      out_in.temp_tenths = frac5_ff.ok ? sum[TEMP_W-1:0] : '0;
      out_in.valid_res   = frac5_ff.ok;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         frac3_ff <= frac3_in;
         frac4_ff <= frac4_in;
         frac5_ff <= frac5_in;
         out_ff   <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   assign out_vld = vld_ff[3];
   assign out_res = out_ff;

endmodule

`default_nettype wire

// File: design/thermistor_adc_to_temperature_core.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// NTC thermistor sample to temperature in tenths of a degree, by divider,
// table search and linear interpolation.
//
//   channel  direction  fields (lowest bit up)
//   req_     in         tdata: adc_sample[11:0], zero fill
//   rsp_     out        tdata: temp_tenths[9:0], zero fill; tuser: valid_res
//
// One transaction enters per cycle while the output is not stalled, and each
// gives one result transaction. The divider pipeline resolves 4 quotient bits
// per stage.
// Synchronous reset clears the valid bits only; no clearing pass.
// A stalled output holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_adc_to_temperature_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [tatc_pkg::REQ_DATA_W-1:0]     req_tdata,  // adc_sample
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [tatc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // temp_tenths
   output      logic                                rsp_tuser   // valid_res
);
   import tatc_pkg::*;

   logic         adv;
   logic         res_vld;
   tatc_res_type res;
   logic         sel_vld;
   tatc_sel_type sel;
   tatc_out_type out_res;

   // the whole pipeline moves unless the output holds a result not yet taken
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   tatc_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_vld     (req_tvalid),
      .adc_sample (req_tdata[ADC_W-1:0]),
      .out_vld    (res_vld),
      .out_res    (res)
   );

   tatc_search u_search (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (res_vld),
      .in_res  (res),
      .out_vld (sel_vld),
      .out_sel (sel)
   );

   tatc_interp u_interp (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (sel_vld),
      .in_sel  (sel),
      .out_vld (rsp_tvalid),
      .out_res (out_res)
   );

   // result transaction packing
   assign rsp_tdata = {{(RSP_DATA_W - TEMP_W){1'b0}}, out_res.temp_tenths};
   assign rsp_tuser = out_res.valid_res;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the thermistor sample-to-temperature core. A directed
// table (rail values, the edges of the valid range, exact table hits) runs
// first, then random samples weighted toward the valid band. Each accepted
// sample's result is typed in (rail rows) or computed from the divider formula
// and the resistance table, then compared in order with the rsp_ stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import tatc_pkg::*;

   localparam int NUM_RANDOM   = 900;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int DEG_OFFSET   = 10;
   localparam int TENTHS_DEG   = 10;

   typedef struct packed {
      logic [ADC_W-1:0]  adc;
      logic [TEMP_W-1:0] temp;
      logic              in_range;
   } temp_result_type;

   typedef struct packed {
      bit              known;
      temp_result_type res;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   longint           ntc_fx [NUM_ENTRIES];
   temp_result_type  pending_temps [$];
   logic [ADC_W-1:0] boundary_adcs [$];
   int               first_valid;
   int               last_valid;
   int               mismatches  = 0;
   int               idle_cycles = 0;
   bit               calm        = 1'b0;
   bit               hold_go     = 1'b0;

   thermistor_adc_to_temperature_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // adc_sample[11:0], zero fill
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // temp_tenths[9:0], zero fill
      .rsp_tuser  (rsp_tuser)    // valid_res
   );

   always #6 clock = ~clock;

   // thermistor resistance in fixed point, sample below full scale
   function automatic longint divider_resistance(logic [ADC_W-1:0] adc);
      return (longint'(DIVIDER_KOHM) * longint'(adc) << FRAC_BITS) /
             (longint'(ADC_FULL) - longint'(adc));
   endfunction

   // table search and interpolation, truncated toward zero
   function automatic temp_result_type ntc_temperature(logic [ADC_W-1:0] adc);
      temp_result_type res;
      longint          r;
      longint          hi;
      longint          lo;
      longint          base;
      longint          num;
      longint          den;
      longint          t;
      res.adc      = adc;
      res.temp     = '0;
      res.in_range = 1'b0;
      if (adc == ADC_FULL)
         return res;
      r = divider_resistance(adc);
      for (int i = 0; i + 1 < NUM_ENTRIES; i++) begin
         hi = ntc_fx[i];
         lo = ntc_fx[i+1];
         if (r <= hi && r >= lo) begin
            base = longint'(i - DEG_OFFSET) * TENTHS_DEG;
            num  = TENTHS_DEG * (hi - r);
            den  = hi - lo;
            // flat interval contributes no fraction
            if (den == 0)
               t = base;
            else if (base >= 0)
               t = base + num / den;
            else
               t = -(((-base) * den - num) / den);
            res.temp     = t[TEMP_W-1:0];
            res.in_range = 1'b1;
            return res;
         end
      end
      return res;
   endfunction

   function automatic stim_row_type mk_row(logic [ADC_W-1:0] adc, bit known,
                                           logic [TEMP_W-1:0] temp, logic in_range);
      stim_row_type row;
      row.known        = known;
      row.res.adc      = adc;
      row.res.temp     = temp;
      row.res.in_range = in_range;
      return row;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // offer one sample and record its expected result once the transaction is taken
   task automatic drive_sample(input stim_row_type row);
      temp_result_type want;
      if (!calm && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(row.res.adc);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = row.known ? row.res : ntc_temperature(row.res.adc);
      pending_temps.push_back(want);
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_go) begin
            hold_go    = 1'b0;
            stall_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 8);
         end
      end
   end

   // compare each result transaction with the oldest pending one
   always @(posedge clock) begin : monitor
      temp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_temps.size() == 0) begin
            report_mismatch($sformatf("unexpected result temp=%0d valid=%0b",
                                      $signed(rsp_tdata[TEMP_W-1:0]), rsp_tuser));
         end else begin
            want = pending_temps.pop_front();
            if (rsp_tdata[TEMP_W-1:0] !== want.temp)
               report_mismatch($sformatf("adc=%0d temp_tenths=%0d, want %0d", want.adc,
                                         $signed(rsp_tdata[TEMP_W-1:0]),
                                         $signed(want.temp)));
            if (rsp_tuser !== want.in_range)
               report_mismatch($sformatf("adc=%0d valid_res=%0b, want %0b", want.adc,
                                         rsp_tuser, want.in_range));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type     directed [$];
      temp_result_type  probe;
      longint           r;
      int               pick;
      logic [ADC_W-1:0] adc;

      // resistance table in fixed point, rounded half up
      for (int i = 0; i < NUM_ENTRIES; i++)
         ntc_fx[i] = ((longint'(NTC_KOHM_E4[i]) << FRAC_BITS) + 5000) / 10000;

      // valid band edges and samples that land exactly on a table entry
      first_valid = -1;
      last_valid  = -1;
      for (int a = 0; a < ADC_FULL; a++) begin
         probe = ntc_temperature(ADC_W'(a));
         if (probe.in_range) begin
            if (first_valid < 0)
               first_valid = a;
            last_valid = a;
         end
         r = divider_resistance(ADC_W'(a));
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (r == ntc_fx[i])
               boundary_adcs.push_back(ADC_W'(a));
      end

      // directed table: rails and out-of-range readings typed in, the rest computed
      directed.push_back(mk_row(12'd0,    1'b1, '0, 1'b0));
      directed.push_back(mk_row(12'd1,    1'b1, '0, 1'b0));
      directed.push_back(mk_row(12'd4095, 1'b1, '0, 1'b0));
      directed.push_back(mk_row(12'd4094, 1'b1, '0, 1'b0));
      directed.push_back(mk_row(12'h555,  1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'haaa,  1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'h7ff,  1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'h800,  1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'd1500, 1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'd2000, 1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'd2500, 1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'd3000, 1'b0, '0, 1'b0));
      directed.push_back(mk_row(12'd3300, 1'b0, '0, 1'b0));
      directed.push_back(mk_row(ADC_W'(first_valid - 1), 1'b0, '0, 1'b0));
      directed.push_back(mk_row(ADC_W'(first_valid),     1'b0, '0, 1'b0));
      directed.push_back(mk_row(ADC_W'(last_valid),      1'b0, '0, 1'b0));
      directed.push_back(mk_row(ADC_W'(last_valid + 1),  1'b0, '0, 1'b0));
      for (int i = 0; i < boundary_adcs.size() && i < 4; i++)
         directed.push_back(mk_row(boundary_adcs[i], 1'b0, '0, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         drive_sample(directed[i]);

      // random samples, mostly inside the table band
      for (int k = 0; k < NUM_RANDOM; k++) begin
         if (k == 50)
            hold_go = 1'b1;
         calm = (k >= 400 && k < 600);
         pick = $urandom_range(99);
         if (pick < 70)
            adc = ADC_W'($urandom_range(last_valid + 8, first_valid - 8));
         else if (pick < 78 && boundary_adcs.size() > 0)
            adc = boundary_adcs[$urandom_range(boundary_adcs.size() - 1)];
         else if (pick < 81)
            adc = ADC_FULL;
         else
            adc = ADC_W'($urandom_range(ADC_FULL));
         drive_sample(mk_row(adc, 1'b0, '0, 1'b0));
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      // drain, then leave room for stray results
      while (pending_temps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
design/tatc_pkg.sv
design/tatc_divider.sv
design/tatc_search.sv
design/tatc_interp.sv
design/thermistor_adc_to_temperature_core.sv
sim/tb.sv
